// ===== rtl/core/svpwm_pkg.sv =====
// Shared types and constants for the space-vector PWM duty generator.
// Holds the base sine table (unsigned 0.16), register indexes and field widths.
// No dependencies.
package svpwm_pkg;

  // Field and register widths
  localparam int unsigned MagW    = 16;
  localparam int unsigned PhaseW  = 9;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned PeriodW = 15;
  localparam int unsigned OffsetW = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned AngleW  = 6;
  localparam int unsigned SectorW = 3;

  // Degrees in one sector and number of sectors
  localparam logic [AngleW-1:0]  SectorDeg = 6'd60;
  localparam logic [SectorW-1:0] NumSectors = 3'd6;
  localparam int unsigned        SineEntries = 61;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PWM_PERIOD  = 1'b0,
    REG_ZERO_OFFSET = 1'b1
  } cfg_reg_e;

  typedef logic [15:0] sine_base_t [SineEntries];

  // sin(k degrees), k = 0..60, unsigned 0.16, rounded to nearest
  localparam sine_base_t SineBase = '{
        16'd0,  16'd1144,  16'd2287,  16'd3430,  16'd4572,
     16'd5712,  16'd6850,  16'd7987,  16'd9121, 16'd10252,
    16'd11380, 16'd12505, 16'd13626, 16'd14742, 16'd15855,
    16'd16962, 16'd18064, 16'd19161, 16'd20252, 16'd21336,
    16'd22415, 16'd23486, 16'd24550, 16'd25607, 16'd26656,
    16'd27697, 16'd28729, 16'd29753, 16'd30767, 16'd31772,
    16'd32768, 16'd33754, 16'd34729, 16'd35693, 16'd36647,
    16'd37590, 16'd38521, 16'd39441, 16'd40348, 16'd41243,
    16'd42126, 16'd42995, 16'd43852, 16'd44695, 16'd45525,
    16'd46341, 16'd47143, 16'd47930, 16'd48703, 16'd49461,
    16'd50203, 16'd50931, 16'd51643, 16'd52339, 16'd53020,
    16'd53684, 16'd54332, 16'd54963, 16'd55578, 16'd56175,
    16'd56756
  };

endpackage

// ===== rtl/core/space_vector_pwm_duty.sv =====
// An accepted input transaction passes the stage 1, 2, 3 and output registers in order.
// Throughput: one transaction per cycle while the output is not held; four register
// stages (sector split, sine ROM read, multiply, route and offset add) advance together.
// A held output stalls every stage at once; nothing is dropped or repeated.
// Reset: pwm_period returns to 1024, zero_vector_offset to 64, the pipeline empties.
// Space-vector PWM duty generator top level; uses svpwm_pkg.
module space_vector_pwm_duty #(
  parameter int unsigned SINE_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [svpwm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [svpwm_pkg::CfgW-1:0]         cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [31:0]                        s_axis_tdata,  // magnitude[15:0], phase_deg[24:16]
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [47:0]                        m_axis_tdata   // duty_a, duty_b, duty_c
);
  import svpwm_pkg::*;

  localparam int unsigned SineW = SINE_FRAC_BITS;
  localparam int unsigned ProdW = PeriodW + SineW;

  typedef logic [SineW-1:0] sine_tbl_t [SineEntries];

  // Sine table rescaled to SINE_FRAC_BITS fraction bits at elaboration
  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t   tbl;
    logic [63:0] v;
    logic [63:0] half;
    int unsigned up;
    int unsigned down;
    up   = (SINE_FRAC_BITS >= 16) ? SINE_FRAC_BITS - 16 : 0;
    down = (SINE_FRAC_BITS < 16) ? 16 - SINE_FRAC_BITS : 0;
    half = (down != 0) ? (64'd1 << (down - 1)) : 64'd0;
    for (int k = 0; k < SineEntries; k++) begin
      v = 64'(SineBase[k]);
      v = ((v << up) + half) >> down;
      tbl[k] = v[SineW-1:0];
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SineTbl = build_sine_tbl();

  // Configuration registers
  logic [PeriodW-1:0] period_q;
  logic [OffsetW-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodW'(1024);
      offset_q <= OffsetW'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PWM_PERIOD:  period_q <= cfg_wdata_i[PeriodW-1:0];
        REG_ZERO_OFFSET: offset_q <= cfg_wdata_i[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: whole pipe moves unless the output is held
  logic adv;
  logic out_valid_q;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: sector split and magnitude saturation
  logic [MagW-1:0]    mag_in;
  logic [PhaseW-1:0]  phase_in;
  logic [3:0]         sec_raw;
  logic [PhaseW-1:0]  sec_base;
  logic [PhaseW-1:0]  ang_full;
  logic [SectorW-1:0] sec_d;
  logic [PeriodW-1:0] mag_sat;

  assign mag_in   = s_axis_tdata[MagW-1:0];
  assign phase_in = s_axis_tdata[MagW +: PhaseW];

  always_comb begin
    sec_raw  = 4'd0;
    sec_base = '0;
    for (int k = 1; k <= 8; k++) begin
      if (phase_in >= PhaseW'(60 * k)) begin
        sec_raw  = 4'(k);
        sec_base = PhaseW'(60 * k);
      end
    end
    ang_full = phase_in - sec_base;
    sec_d    = (sec_raw >= 4'(NumSectors)) ? 3'(sec_raw - 4'(NumSectors)) : sec_raw[2:0];
    mag_sat  = (mag_in > MagW'(period_q)) ? period_q : mag_in[PeriodW-1:0];
  end

  logic               v1_q;
  logic [PeriodW-1:0] mag1_q;
  logic [SectorW-1:0] sec1_q;
  logic [AngleW-1:0]  ang1_q;

  // Stage 2: sine ROM reads
  logic               v2_q;
  logic [PeriodW-1:0] mag2_q;
  logic [SectorW-1:0] sec2_q;
  logic [SineW-1:0]   sin_ang2_q;
  logic [SineW-1:0]   sin_cmp2_q;

  // Stage 3: active-vector times
  logic               v3_q;
  logic [SectorW-1:0] sec3_q;
  logic [PeriodW-1:0] t1_q;
  logic [PeriodW-1:0] t2_q;
  logic [ProdW-1:0]   prod_t1;
  logic [ProdW-1:0]   prod_t2;

  assign prod_t2 = ProdW'(mag2_q) * ProdW'(sin_ang2_q);
  assign prod_t1 = ProdW'(mag2_q) * ProdW'(sin_cmp2_q);

  // Stage 4: per-sector routing and offset add
  logic [DutyW-1:0] t_sum;
  logic [DutyW-1:0] t1_w;
  logic [DutyW-1:0] t2_w;
  logic [DutyW-1:0] ra, rb, rc;
  logic [DutyW-1:0] duty_a_q, duty_b_q, duty_c_q;

  assign t1_w  = DutyW'(t1_q);
  assign t2_w  = DutyW'(t2_q);
  assign t_sum = t1_w + t2_w;

  always_comb begin
    case (sec3_q)
      3'd0:    begin ra = t_sum; rb = t2_w;  rc = '0;    end
      3'd1:    begin ra = t1_w;  rb = t_sum; rc = '0;    end
      3'd2:    begin ra = '0;    rb = t_sum; rc = t2_w;  end
      3'd3:    begin ra = '0;    rb = t1_w;  rc = t_sum; end
      3'd4:    begin ra = t2_w;  rb = '0;    rc = t_sum; end
      default: begin ra = t_sum; rb = '0;    rc = t1_w;  end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= s_axis_tvalid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag1_q     <= mag_sat;
      sec1_q     <= sec_d;
      ang1_q     <= ang_full[AngleW-1:0];

      mag2_q     <= mag1_q;
      sec2_q     <= sec1_q;
      sin_ang2_q <= SineTbl[ang1_q];
      sin_cmp2_q <= SineTbl[SectorDeg - ang1_q];

      sec3_q     <= sec2_q;
      t2_q       <= prod_t2[SineW +: PeriodW];
      t1_q       <= prod_t1[SineW +: PeriodW];

      duty_a_q   <= ra + DutyW'(offset_q);
      duty_b_q   <= rb + DutyW'(offset_q);
      duty_c_q   <= rc + DutyW'(offset_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {duty_c_q, duty_b_q, duty_a_q};

`ifndef SYNTHESIS
  // sector is folded into 0..5
  assert property (@(posedge clk_i) disable iff (!rst_ni) v1_q |-> sec1_q < NumSectors)
    else $error("sector out of range");
  // angle within a sector stays below 60
  assert property (@(posedge clk_i) disable iff (!rst_ni) v1_q |-> ang1_q < SectorDeg)
    else $error("angle out of range");
  // a stall freezes every valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v1_q, v2_q, v3_q, out_valid_q}))
    else $error("pipeline moved during stall");
  // a new output transaction comes from the last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(v3_q))
    else $error("output valid without stage 3 valid");
`endif

endmodule
